// ===== rtl/core/pwbfr_pkg.sv =====
// Shared types, codes and the CRC-8 helper for the pulse width bus frame receiver.
package pwbfr_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_BIT_PERIOD    = 2'd0;
    localparam logic [1:0] CFG_OWN_ADDRESS   = 2'd1;
    localparam logic [1:0] CFG_BCAST_ADDRESS = 2'd2;

    // Reset values of the configuration registers
    localparam logic [4:0] BIT_PERIOD_RESET    = 5'd8;
    localparam logic [7:0] OWN_ADDRESS_RESET   = 8'd0;
    localparam logic [7:0] BCAST_ADDRESS_RESET = 8'd255;

    // Result status codes
    localparam logic [1:0] STATUS_BYTE     = 2'd0;
    localparam logic [1:0] STATUS_CRC_GOOD = 2'd1;
    localparam logic [1:0] STATUS_CRC_BAD  = 2'd2;
    localparam logic [1:0] STATUS_ABORT    = 2'd3;

    // Reflected CRC-8 polynomial
    localparam logic [7:0] CRC_POLY = 8'h8C;

    // One result item
    typedef struct packed {
        logic [7:0] byte_value;
        logic [7:0] byte_index;
        logic [1:0] status;
        logic       for_us;
    } result_t;

    // Fold one byte into the running CRC, LSB first
    function automatic logic [7:0] crc_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] crc;
        logic [7:0] d;
        logic       mix;
        crc = crc_in;
        d   = data;
        for (int k = 0; k < 8; k++)
        begin
            mix = crc[0] ^ d[0];
            crc = crc >> 1;
            if (mix)
            begin
                crc = crc ^ CRC_POLY;
            end
            d = d >> 1;
        end
        return crc;
    endfunction

endpackage

// ===== rtl/core/pwbfr_frame_fsm.sv =====
// Frame state machine: pulse measurement, bit assembly, CRC and frame end checks.
module pwbfr_frame_fsm #(
    parameter int MAX_FRAME = 128
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 line_low,
    input  logic [7:0]           timestamp,
    input  logic [4:0]           bit_period,
    input  logic [7:0]           own_address,
    input  logic [7:0]           broadcast_address,
    output logic                 has_result,
    output pwbfr_pkg::result_t   result
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PRIO1,
        PH_PRIO2,
        PH_DATA
    } phase_t;

    localparam logic [7:0] MaxFrameCount = 8'(MAX_FRAME);

    phase_t     phase_reg;
    logic [7:0] pulse_start_reg;
    logic [7:0] byte_cnt_reg;
    logic [2:0] bit_cnt_reg;
    logic [7:0] shift_reg;
    logic [7:0] crc_reg;
    logic [7:0] size_reg;
    logic [7:0] sender_reg;
    logic [7:0] target_reg;

    logic [7:0] ticks;
    logic [8:0] start_prod;
    logic [7:0] start_thr;
    logic [7:0] one_thr;
    logic       is_start;
    logic       data_pulse;
    logic [7:0] shift_next;
    logic       byte_done;
    logic [7:0] byte_cnt_next;
    logic [7:0] crc_next;
    logic [7:0] size_next;
    logic [7:0] sender_next;
    logic [7:0] target_next;
    logic       frame_end;
    logic       frame_abort;

    // Measure the pulse and compare against the start and one thresholds
    always_comb
    begin
        ticks      = timestamp - pulse_start_reg;
        start_prod = {4'b0, bit_period} * 9'd13;
        start_thr  = start_prod[8:1];
        one_thr    = {2'b0, bit_period, 1'b0};
        is_start   = !line_low && (ticks >= start_thr);
        data_pulse = !line_low && !is_start && (phase_reg == PH_DATA);
        shift_next = shift_reg;
        if (ticks > one_thr)
        begin
            shift_next = shift_reg | (8'd1 << bit_cnt_reg);
        end
        byte_done = data_pulse && (bit_cnt_reg == 3'd7);
    end

    // Work out the byte bookkeeping and the frame end
    always_comb
    begin
        byte_cnt_next = byte_cnt_reg + 8'd1;
        crc_next      = pwbfr_pkg::crc_byte(crc_reg, shift_next);
        size_next     = (byte_cnt_reg == 8'd3) ? shift_next : size_reg;
        sender_next   = (byte_cnt_reg == 8'd0) ? shift_next : sender_reg;
        target_next   = (byte_cnt_reg == 8'd1) ? shift_next : target_reg;
        frame_end     = (byte_cnt_next > 8'd3) &&
                        ({1'b0, byte_cnt_next} > ({1'b0, size_next} + 9'd4));
        frame_abort   = !frame_end && (byte_cnt_next >= MaxFrameCount);

        has_result        = byte_done;
        result.byte_value = shift_next;
        result.byte_index = byte_cnt_reg;
        result.status     = pwbfr_pkg::STATUS_BYTE;
        result.for_us     = 1'b0;
        if (frame_end)
        begin
            result.status = (crc_next == 8'd0) ? pwbfr_pkg::STATUS_CRC_GOOD
                                               : pwbfr_pkg::STATUS_CRC_BAD;
            result.for_us = (sender_next != own_address) &&
                            ((target_next == own_address) ||
                             (target_next == broadcast_address));
        end
        else if (frame_abort)
        begin
            result.status = pwbfr_pkg::STATUS_ABORT;
        end
    end

    // Advance the frame state on each item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            pulse_start_reg <= 8'd0;
            byte_cnt_reg    <= 8'd0;
            bit_cnt_reg     <= 3'd0;
            shift_reg       <= 8'd0;
            crc_reg         <= 8'd0;
            size_reg        <= 8'd0;
            sender_reg      <= 8'd0;
            target_reg      <= 8'd0;
        end
        else if (step)
        begin
            if (line_low)
            begin
                pulse_start_reg <= timestamp;
            end
            else if (is_start)
            begin
                phase_reg <= PH_PRIO1;
            end
            else
            begin
                case (phase_reg)
                    PH_PRIO1:
                    begin
                        phase_reg <= PH_PRIO2;
                    end
                    PH_PRIO2:
                    begin
                        phase_reg    <= PH_DATA;
                        byte_cnt_reg <= 8'd0;
                        bit_cnt_reg  <= 3'd0;
                        shift_reg    <= 8'd0;
                        crc_reg      <= 8'd0;
                    end
                    PH_DATA:
                    begin
                        bit_cnt_reg <= bit_cnt_reg + 3'd1;
                        if (byte_done)
                        begin
                            shift_reg    <= 8'd0;
                            crc_reg      <= crc_next;
                            size_reg     <= size_next;
                            sender_reg   <= sender_next;
                            target_reg   <= target_next;
                            byte_cnt_reg <= byte_cnt_next;
                            if (frame_end || frame_abort)
                            begin
                                phase_reg <= PH_IDLE;
                            end
                        end
                        else
                        begin
                            shift_reg <= shift_next;
                        end
                    end
                    default:
                    begin
                        phase_reg <= phase_reg;
                    end
                endcase
            end
        end
    end

endmodule

// ===== rtl/core/pulse_width_bus_frame_receiver_top.sv =====
// Top level of the pulse width bus frame receiver: channels, config and result register.
//
// Input channel: one line edge per item (line_low = 1 for a falling edge,
// 0 for a release) with the 8-bit timer stamp taken at that edge. Output
// channel: one result item for each completed frame byte, carrying its value,
// its index in the frame and a status; the last byte of a frame reports CRC
// good or bad and for_us, and a frame that runs to MAX_FRAME bytes ends with
// an abort status. Edges that complete no byte give no result.
// Configuration: cfg_write with cfg_index/cfg_data writes bit_period,
// own_address or broadcast_address; write only while the block is idle.
// Result path: an accepted item lands in the input register, and its result is
// registered into the result register when that item advances from there.
// Throughput: one item per cycle while in_stall is low; the frame state
// update and byte-wide CRC fold are combinational between the input and result registers.
// Stall: while out_stall holds a waiting result, items that make no result
// still pass; an item that would make one holds the input register and
// in_stall rises. Reset clears the frame state to idle, empties both
// registers and loads the configuration reset values.
module pulse_width_bus_frame_receiver_top #(
    parameter int MAX_FRAME = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       line_low,
    input  logic [7:0] timestamp,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] byte_value,
    output logic [7:0] byte_index,
    output logic [1:0] status,
    output logic       for_us,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic       s1_valid_reg;
    logic       s1_line_low_reg;
    logic [7:0] s1_timestamp_reg;
    logic       out_valid_reg;
    pwbfr_pkg::result_t out_reg;
    logic [4:0] bit_period_reg;
    logic [7:0] own_address_reg;
    logic [7:0] bcast_address_reg;

    logic               has_result;
    pwbfr_pkg::result_t result;
    logic               out_free;
    logic               advance;

    // Move the held item forward unless its result would hit a stalled output
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && (out_free || !has_result);
    assign in_stall = s1_valid_reg && !advance;

    pwbfr_frame_fsm #(
        .MAX_FRAME (MAX_FRAME)
    ) u_frame_fsm (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (advance),
        .line_low          (s1_line_low_reg),
        .timestamp         (s1_timestamp_reg),
        .bit_period        (bit_period_reg),
        .own_address       (own_address_reg),
        .broadcast_address (bcast_address_reg),
        .has_result        (has_result),
        .result            (result)
    );

    // Hold the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg    <= pwbfr_pkg::BIT_PERIOD_RESET;
            own_address_reg   <= pwbfr_pkg::OWN_ADDRESS_RESET;
            bcast_address_reg <= pwbfr_pkg::BCAST_ADDRESS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                pwbfr_pkg::CFG_BIT_PERIOD:    bit_period_reg    <= cfg_data[4:0];
                pwbfr_pkg::CFG_OWN_ADDRESS:   own_address_reg   <= cfg_data;
                pwbfr_pkg::CFG_BCAST_ADDRESS: bcast_address_reg <= cfg_data;
                default:                      bit_period_reg    <= bit_period_reg;
            endcase
        end
    end

    // Capture input items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_line_low_reg  <= line_low;
            s1_timestamp_reg <= timestamp;
        end
    end

    // Hold the result register until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && has_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && advance && has_result)
        begin
            out_reg <= result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign byte_value = out_reg.byte_value;
    assign byte_index = out_reg.byte_index;
    assign status     = out_reg.status;
    assign for_us     = out_reg.for_us;

    // for_us is only ever reported on a frame end
    a_for_us_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.for_us |->
            (out_reg.status == pwbfr_pkg::STATUS_CRC_GOOD) ||
            (out_reg.status == pwbfr_pkg::STATUS_CRC_BAD))
        else $error("for_us set on a result that is not a frame end");

    // A frame end needs at least the four header bytes plus the CRC byte
    a_end_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ((out_reg.status == pwbfr_pkg::STATUS_CRC_GOOD) ||
                          (out_reg.status == pwbfr_pkg::STATUS_CRC_BAD)) |->
            out_reg.byte_index >= 8'd4)
        else $error("frame end reported before the CRC byte could arrive");

    // An abort happens exactly on the last byte that fits
    a_abort_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.status == pwbfr_pkg::STATUS_ABORT) |->
            out_reg.byte_index == 8'(MAX_FRAME - 1))
        else $error("abort reported at the wrong byte index");

    // Back-pressure only when a result is blocked behind a stalled output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && has_result && out_valid_reg && out_stall)
        else $error("input stalled without a blocked result");

endmodule
